>>> hdl/gfr_pkg.sv
`default_nettype none

package gfr_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 32;

  localparam int GLYPH_ADVANCE = 6;
  localparam int CURSOR_MAX    = 255;
  localparam int CODE_FIRST    = 32;
  localparam int CODE_LAST     = 127;
  localparam int CODE_FALLBACK = 63;  // question mark

  // Two store bytes per glyph column (upper and lower page), five columns.
  localparam int GLYPH_STEPS = 10;

  // Write request for one store byte, produced by the pixel unit.
  typedef struct packed {
    logic       wr_en;
    logic [7:0] bits;
  } pix_ctl_t;

  // Font table: column 0 of a glyph sits in the top byte, column 4 in the bottom byte.
  // Bit b of a column lights row b of the glyph.
  localparam logic [39:0] FONT_ROM [96] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
    40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
    40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
    40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
    40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
    40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h10_08_08_10_08, 40'h00_00_00_00_00
  };

  // Maps a character byte to its font entry; unprintable codes fall back to '?'.
  function automatic logic [6:0] glyph_index(logic [7:0] code);
    logic [7:0] c;
    c = code;
    if ((c < 8'(CODE_FIRST)) || (c > 8'(CODE_LAST))) begin
      c = 8'(CODE_FALLBACK);
    end
    return 7'(c - 8'(CODE_FIRST));
  endfunction

  // Cursor advance by one glyph cell, saturating at the right limit.
  function automatic logic [8:0] advance(logic [8:0] x);
    logic [9:0] n;
    n = {x[8], x} + 10'(GLYPH_ADVANCE);
    if ($signed(n) > $signed(10'(CURSOR_MAX))) begin
      return 9'(CURSOR_MAX);
    end
    return n[8:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/gfr_frame_mem.sv
`default_nettype none

// Framebuffer store: one write port and one registered read port.
module gfr_frame_mem #(
  parameter int DEPTH  = gfr_pkg::DEF_SCREEN_WIDTH * ((gfr_pkg::DEF_SCREEN_HEIGHT + 7) / 8),
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/gfr_pixel_unit.sv
`default_nettype none

// Shared address and mask unit: maps one sequencer step (glyph column and
// page half) to a store address and the bits to OR in, with clipping.
module gfr_pixel_unit #(
  parameter int SCREEN_WIDTH  = gfr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = gfr_pkg::DEF_SCREEN_HEIGHT,
  parameter int ADDR_W        = 9
) (
  input  wire logic [8:0]        x_i,
  input  wire logic [6:0]        y_i,
  input  wire logic [3:0]        step_i,
  input  wire logic [39:0]       glyph_i,
  output logic      [ADDR_W-1:0] addr_o,
  output gfr_pkg::pix_ctl_t      ctl_o
);

  localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
  localparam int LAST_ROWS  = SCREEN_HEIGHT - (PAGE_COUNT - 1) * 8;
  localparam logic [7:0] LAST_MASK = 8'((16'd1 << LAST_ROWS) - 16'd1);

  logic [2:0]  col;
  logic        half;
  logic [7:0]  col_byte;
  logic [9:0]  px;
  logic        px_ok;
  logic [4:0]  page;
  logic        page_ok;
  logic [15:0] shifted;
  logic [7:0]  row_mask;
  logic [11:0] sum;

  assign col  = step_i[3:1];
  assign half = step_i[0];

  always_comb begin
    case (col)
      3'd0:    col_byte = glyph_i[39:32];
      3'd1:    col_byte = glyph_i[31:24];
      3'd2:    col_byte = glyph_i[23:16];
      3'd3:    col_byte = glyph_i[15:8];
      3'd4:    col_byte = glyph_i[7:0];
      default: col_byte = 8'h00;
    endcase
  end

  assign px    = {x_i[8], x_i} + {7'b0, col};
  assign px_ok = !px[9] && ({1'b0, px[8:0]} < 10'(SCREEN_WIDTH));

  // Floor of y / 8 selects the upper page; the lower half spills into the next one.
  assign page    = {y_i[6], y_i[6:3]} + {4'b0, half};
  assign page_ok = !page[4] && ({1'b0, page[3:0]} < 5'(PAGE_COUNT));

  assign shifted  = {9'b0, col_byte[6:0]} << y_i[2:0];
  assign row_mask = (page[3:0] == 4'(PAGE_COUNT - 1)) ? LAST_MASK : 8'hFF;

  assign sum    = {3'b0, px[8:0]} + 12'(page[3:0]) * 12'(SCREEN_WIDTH);
  assign addr_o = sum[ADDR_W-1:0];

  assign ctl_o.wr_en = px_ok && page_ok && (step_i < 4'(gfr_pkg::GLYPH_STEPS));
  assign ctl_o.bits  = (half ? shifted[15:8] : shifted[7:0]) & row_mask;

endmodule

`default_nettype wire

>>> hdl/glyph_framebuffer_renderer.sv
`default_nettype none

// 5x7 character generator over a page-organized monochrome framebuffer.
// The slave stream carries requests: tuser holds the mode (clear, draw at x,y,
// draw at cursor, read byte) and tdata the position, character and read address.
// The master stream returns exactly one result transaction per request: tdata is
// the framebuffer byte for a read and zero otherwise, tuser flags a read answer.
// Items are handled one at a time; s_axis_tready is high only while the
// sequencer is idle. A draw runs through the accepting cycle, which latches
// the glyph, then eleven steps in which the single pixel unit and the store
// read-modify-write up to ten bytes (one byte read and the previous one
// written each cycle), then the result state, which waits for a free output
// register. A read issues its store read on acceptance; the result state
// moves the registered store byte into the output register. A clear sweeps
// all SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) store bytes one byte a cycle,
// then passes through the result state.
// After reset the same sweep zeroes the store (512 bytes at the default size)
// before the first request is taken; the cursor resets to the origin.
// A finished result sits in an output register. A new request may be accepted
// while it waits; if the receiver still stalls when that request completes,
// the sequencer holds its result until the output register frees up.
module glyph_framebuffer_renderer #(
  parameter int SCREEN_WIDTH  = gfr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = gfr_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [8:0] x_pos, [15:9] y_pos, [23:16] char_code, [32:24] read_addr, rest zero
  input  wire logic [39:0] s_axis_tdata,
  // [1:0] mode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data
  output logic      [7:0]  m_axis_tdata,
  // [0] is_read
  output logic             m_axis_tuser
);

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_BYTES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    MODE_CLEAR       = 2'd0,
    MODE_DRAW_XY     = 2'd1,
    MODE_DRAW_CURSOR = 2'd2,
    MODE_READ        = 2'd3
  } mode_e;

  state_e             state_q;
  logic [AW-1:0]      clr_cnt_q;
  logic               clr_resp_q;
  logic [3:0]         step_q;
  logic [8:0]         base_x_q;
  logic [6:0]         base_y_q;
  logic [39:0]        glyph_q;
  logic [8:0]         cursor_x_q;
  logic [6:0]         cursor_y_q;
  gfr_pkg::pix_ctl_t  pend_ctl_q;
  logic [AW-1:0]      pend_addr_q;
  logic               in_range_q;
  logic               res_is_read_q;
  logic               out_valid_q;
  logic [7:0]         out_data_q;
  logic               out_user_q;

  mode_e              in_mode;
  logic [8:0]         in_x;
  logic [6:0]         in_y;
  logic [7:0]         in_code;
  logic [8:0]         in_addr;
  logic [11:0]        rd_addr_ext;
  logic               rd_in_range;
  logic               accept;
  logic               out_free;

  logic [AW-1:0]      pix_addr;
  gfr_pkg::pix_ctl_t  pix_ctl;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         mem_rdata;

  assign in_mode     = mode_e'(s_axis_tuser);
  assign in_x        = s_axis_tdata[8:0];
  assign in_y        = s_axis_tdata[15:9];
  assign in_code     = s_axis_tdata[23:16];
  assign in_addr     = s_axis_tdata[32:24];
  assign rd_addr_ext = {3'b0, in_addr};
  assign rd_in_range = rd_addr_ext < 12'(STORE_BYTES);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  gfr_pixel_unit #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ADDR_W        (AW)
  ) u_pixel (
    .x_i     (base_x_q),
    .y_i     (base_y_q),
    .step_i  (step_q),
    .glyph_i (glyph_q),
    .addr_o  (pix_addr),
    .ctl_o   (pix_ctl)
  );

  gfr_frame_mem #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Store port steering. During a draw the byte for the current step is read
  // while the byte fetched in the previous step is written back with its new bits.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
      end
      ST_IDLE: begin
        mem_re    = accept && (in_mode == MODE_READ) && rd_in_range;
        mem_raddr = rd_addr_ext[AW-1:0];
      end
      ST_DRAW: begin
        mem_re    = pix_ctl.wr_en;
        mem_raddr = pix_addr;
        mem_we    = pend_ctl_q.wr_en;
        mem_waddr = pend_addr_q;
        mem_wdata = mem_rdata | pend_ctl_q.bits;
      end
      ST_RESP: begin
        mem_re = 1'b0;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_cnt_q     <= '0;
      clr_resp_q    <= 1'b0;
      step_q        <= '0;
      base_x_q      <= '0;
      base_y_q      <= '0;
      glyph_q       <= '0;
      cursor_x_q    <= '0;
      cursor_y_q    <= '0;
      pend_ctl_q    <= '0;
      pend_addr_q   <= '0;
      in_range_q    <= 1'b0;
      res_is_read_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      out_user_q    <= 1'b0;
    end else begin
      // A taken result empties the output register unless the next one is
      // loaded in the same cycle by the result state.
      if (out_valid_q && m_axis_tready && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_cnt_q == AW'(STORE_BYTES - 1)) begin
            clr_cnt_q <= '0;
            // The sweep after reset owes no result; a requested clear does.
            state_q   <= clr_resp_q ? ST_RESP : ST_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_is_read_q <= 1'b0;
            in_range_q    <= 1'b0;
            step_q        <= '0;
            pend_ctl_q    <= '0;
            unique case (in_mode)
              MODE_CLEAR: begin
                clr_resp_q <= 1'b1;
                state_q    <= ST_CLEAR;
              end
              MODE_DRAW_XY: begin
                base_x_q   <= in_x;
                base_y_q   <= in_y;
                cursor_x_q <= gfr_pkg::advance(in_x);
                cursor_y_q <= in_y;
                glyph_q    <= gfr_pkg::FONT_ROM[gfr_pkg::glyph_index(in_code)];
                state_q    <= ST_DRAW;
              end
              MODE_DRAW_CURSOR: begin
                base_x_q   <= cursor_x_q;
                base_y_q   <= cursor_y_q;
                cursor_x_q <= gfr_pkg::advance(cursor_x_q);
                glyph_q    <= gfr_pkg::FONT_ROM[gfr_pkg::glyph_index(in_code)];
                state_q    <= ST_DRAW;
              end
              MODE_READ: begin
                res_is_read_q <= 1'b1;
                in_range_q    <= rd_in_range;
                state_q       <= ST_RESP;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DRAW: begin
          pend_ctl_q  <= pix_ctl;
          pend_addr_q <= pix_addr;
          step_q      <= step_q + 1'b1;
          // The final step only writes back the last fetched byte.
          if (step_q == 4'(gfr_pkg::GLYPH_STEPS)) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= in_range_q ? mem_rdata : 8'h00;
            out_user_q  <= res_is_read_q;
            clr_resp_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Only read answers may carry store data.
  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'h00))
    else $error("non-read result carries data");

  // No store write, from the pixel unit or the clear sweep, may address past the end of the store.
  a_write_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < STORE_BYTES))
    else $error("store write beyond last byte");

  // One request at a time: the sequencer leaves idle right after acceptance.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("request accepted while previous one in flight");

  // The draw sequencer never runs past its write-back step.
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> (step_q <= 4'(gfr_pkg::GLYPH_STEPS)))
    else $error("draw step counter overrun");

endmodule

`default_nettype wire

>>> dv/glyph_framebuffer_renderer_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the glyph framebuffer renderer. Requests go in on
// the slave stream from a queue filled at time zero. A scoreboard mirrors the
// framebuffer and the text cursor, and checks every result transaction in order.
module glyph_framebuffer_renderer_tb;

  localparam int SCREEN_W       = 128;
  localparam int SCREEN_H       = 32;
  localparam int STORE_BYTES    = SCREEN_W * ((SCREEN_H + 7) / 8);
  localparam int FIRST_PRINTABLE = 32;
  localparam int LAST_PRINTABLE  = 127;
  localparam int FALLBACK_CHAR   = 63;   // question mark
  localparam int CELL_ADVANCE    = 6;
  localparam int PEN_X_MAX       = 255;
  localparam int TOTAL_REQS      = 1000;
  localparam int STALL_LIMIT     = 5000;  // covers the power-up sweep and a clear
  localparam int DRAIN_CYCLES    = 20;

  typedef enum logic [1:0] {
    MODE_CLEAR,
    MODE_DRAW_AT,
    MODE_DRAW_CURSOR,
    MODE_READ
  } req_mode_e;

  typedef struct {
    req_mode_e  mode;
    logic [8:0] x_pos;
    logic [6:0] y_pos;
    logic [7:0] char_code;
    logic [8:0] read_addr;
  } render_req_t;

  typedef struct {
    logic [7:0] read_data;
    logic       is_read;
  } reply_t;

  // 5x7 font for codes 32..127: column 0 in the top byte, bit b is glyph row b.
  localparam logic [39:0] GLYPH_FONT [96] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
    40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
    40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
    40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
    40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
    40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h10_08_08_10_08, 40'h00_00_00_00_00
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [8:0] x_pos, [15:9] y_pos, [23:16] char_code, [32:24] read_addr, rest zero
  logic [39:0] s_axis_tdata  = '0;
  // [1:0] mode
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] read_data
  logic [7:0]  m_axis_tdata;
  // [0] is_read
  logic        m_axis_tuser;

  glyph_framebuffer_renderer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  render_req_t pending_reqs[$];
  reply_t      predicted_replies[$];

  // Mirror of the framebuffer and the text cursor.
  logic [7:0] pixel_map [STORE_BYTES];
  int         pen_x = 0;
  int         pen_y = 0;

  logic req_accepted = 1'b0;
  int   req_gap      = 0;
  int   ready_stall  = 0;
  bit   calm_stretch = 1'b0;
  int   idle_cycles  = 0;
  int   fail_count   = 0;
  int   results_seen = 0;
  int   draws_seen   = 0;
  int   reads_seen   = 0;
  int   lit_reads    = 0;
  int   clears_seen  = 0;

  initial begin
    foreach (pixel_map[i]) pixel_map[i] = 8'h00;
  end

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void queue_req(req_mode_e mode, int x, int y, int code, int addr);
    render_req_t r;
    r.mode      = mode;
    r.x_pos     = 9'(x);
    r.y_pos     = 7'(y);
    r.char_code = 8'(code);
    r.read_addr = 9'(addr);
    pending_reqs.push_back(r);
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  // During a calm stretch nothing idles at all.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm_stretch || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ORs one 5x7 glyph into the mirror, dropping pixels that fall off the screen.
  function automatic void render_glyph(int x0, int y0, logic [7:0] code);
    int         glyph;
    logic [7:0] column;
    int         px;
    int         py;
    glyph = int'(code);
    if (glyph < FIRST_PRINTABLE || glyph > LAST_PRINTABLE) glyph = FALLBACK_CHAR;
    for (int i = 0; i < 5; i++) begin
      column = GLYPH_FONT[glyph - FIRST_PRINTABLE][39 - 8 * i -: 8];
      px = x0 + i;
      if (px >= 0 && px < SCREEN_W) begin
        for (int b = 0; b < 7; b++) begin
          py = y0 + b;
          if (py >= 0 && py < SCREEN_H && column[b]) begin
            pixel_map[px + (py / 8) * SCREEN_W][py % 8] = 1'b1;
          end
        end
      end
    end
  endfunction

  function automatic int next_pen(int x);
    return (x + CELL_ADVANCE > PEN_X_MAX) ? PEN_X_MAX : x + CELL_ADVANCE;
  endfunction

  // Updates the mirror for one accepted request and returns its expected reply.
  function automatic reply_t render_request(req_mode_e mode, logic [39:0] data);
    reply_t     rep;
    int         x;
    int         y;
    logic [8:0] addr;
    x    = $signed(data[8:0]);
    y    = $signed(data[15:9]);
    addr = data[32:24];
    rep.read_data = 8'h00;
    rep.is_read   = 1'b0;
    case (mode)
      MODE_CLEAR: begin
        foreach (pixel_map[i]) pixel_map[i] = 8'h00;
        clears_seen++;
      end
      MODE_DRAW_AT: begin
        render_glyph(x, y, data[23:16]);
        pen_x = next_pen(x);
        pen_y = y;
        draws_seen++;
      end
      MODE_DRAW_CURSOR: begin
        render_glyph(pen_x, pen_y, data[23:16]);
        pen_x = next_pen(pen_x);
        draws_seen++;
      end
      default: begin
        rep.is_read = 1'b1;
        if (int'(addr) < STORE_BYTES) rep.read_data = pixel_map[addr];
        reads_seen++;
        if (rep.read_data != 8'h00) lit_reads++;
      end
    endcase
    return rep;
  endfunction

  // Request driver: inputs move on the falling edge only.
  always @(negedge clk_i) begin
    render_req_t r;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_accepted) begin
      if (req_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        req_gap--;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.mode;
        s_axis_tdata  <= {7'b0, r.read_addr, r.char_code, r.y_pos, r.x_pos};
        if ($urandom_range(0, 49) == 0) calm_stretch = !calm_stretch;
        req_gap = pick_idle();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (ready_stall > 0) begin
      m_axis_tready <= 1'b0;
      ready_stall--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_stall = pick_idle();
    end
  end

  // Both handshakes are sampled on the rising edge; prediction and checking
  // happen here, and the watchdog counts edges on which nothing moved.
  always @(posedge clk_i) begin
    reply_t exp_rep;
    logic   in_fire;
    logic   out_fire;
    in_fire  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    req_accepted <= in_fire;
    if (out_fire) begin
      results_seen++;
      if (predicted_replies.size() == 0) begin
        $error("result transaction with no request outstanding: data %02h user %0b",
               m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        exp_rep = predicted_replies.pop_front();
        if (m_axis_tdata !== exp_rep.read_data) begin
          $error("read_data: expected %02h, got %02h", exp_rep.read_data, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser !== exp_rep.is_read) begin
          $error("is_read: expected %0b, got %0b", exp_rep.is_read, m_axis_tuser);
          fail_count++;
        end
      end
    end
    if (in_fire) begin
      predicted_replies.push_back(render_request(req_mode_e'(s_axis_tuser), s_axis_tdata));
    end
    if (!rst_ni || in_fire || out_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int x0;
    int y0;
    int run_len;
    int col;
    int row;
    int nreads;

    // Directed part: reads of the blank store, clipping at every edge, the
    // fallback and blank glyphs, cursor saturation, and a clear.
    queue_req(MODE_READ, 0, 0, 0, 0);
    queue_req(MODE_DRAW_AT, 0, 0, "A", 0);
    queue_req(MODE_DRAW_CURSOR, 0, 0, "0", 0);
    queue_req(MODE_READ, 0, 0, 0, 6);
    queue_req(MODE_DRAW_AT, 125, 29, "W", 0);         // right and bottom edges
    queue_req(MODE_READ, 0, 0, 0, 511);
    queue_req(MODE_DRAW_AT, -2, -3, "H", 0);          // left and top edges
    queue_req(MODE_READ, 0, 0, 0, 0);
    queue_req(MODE_DRAW_AT, -256, -64, "#", 0);       // entirely off screen
    queue_req(MODE_DRAW_AT, 255, 63, "#", 0);         // cursor saturates
    queue_req(MODE_DRAW_CURSOR, 0, 0, "X", 0);
    queue_req(MODE_DRAW_AT, 40, 5, 0, 0);             // low code, straddles pages
    queue_req(MODE_READ, 0, 0, 0, 42);
    queue_req(MODE_READ, 0, 0, 0, 42 + SCREEN_W);
    queue_req(MODE_DRAW_AT, 50, 12, 255, 0);          // high code
    queue_req(MODE_READ, 0, 0, 0, 50 + SCREEN_W);
    queue_req(MODE_DRAW_AT, 60, 8, 127, 0);           // blank glyph
    queue_req(MODE_READ, 0, 0, 0, 62 + SCREEN_W);
    queue_req(MODE_DRAW_AT, 70, 16, " ", 0);
    queue_req(MODE_DRAW_AT, 80, 24, "~", 0);
    queue_req(MODE_READ, 0, 0, 0, 81 + 3 * SCREEN_W);
    queue_req(MODE_DRAW_AT, 245, 0, "Z", 0);          // advance saturates from 251
    queue_req(MODE_DRAW_CURSOR, 0, 0, "Z", 0);
    queue_req(MODE_CLEAR, 0, 0, 0, 0);
    queue_req(MODE_READ, 0, 0, 0, 0);

    // Random part: mostly short text runs followed by reads aimed at the
    // pixels they touched, with clears, scattered reads and raw noise mixed in.
    while (pending_reqs.size() < TOTAL_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        x0 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) - 10
                                         : $urandom_range(0, SCREEN_W - 1);
        y0 = $urandom_range(0, SCREEN_H + 5) - 6;
        run_len = $urandom_range(0, 6);
        queue_req(MODE_DRAW_AT, x0, y0, $urandom_range(32, 126), 0);
        for (int i = 0; i < run_len; i++) begin
          queue_req(MODE_DRAW_CURSOR, $urandom, $urandom, ($urandom_range(0, 9) == 0)
                    ? $urandom_range(0, 255) : $urandom_range(32, 126), $urandom);
        end
        nreads = $urandom_range(2, 6);
        for (int i = 0; i < nreads; i++) begin
          col = x0 + $urandom_range(0, CELL_ADVANCE * run_len + 4);
          row = y0 + $urandom_range(0, 6);
          if (col < 0 || col >= SCREEN_W) col = $urandom_range(0, SCREEN_W - 1);
          if (row < 0 || row >= SCREEN_H) row = $urandom_range(0, SCREEN_H - 1);
          queue_req(MODE_READ, $urandom, $urandom, $urandom, col + (row / 8) * SCREEN_W);
        end
      end else if (pick < 73) begin
        queue_req(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 88) begin
        nreads = $urandom_range(1, 4);
        for (int i = 0; i < nreads; i++) begin
          queue_req(MODE_READ, $urandom, $urandom, $urandom, $urandom);
        end
      end else begin
        // Noise: every field at random, but no clears since they are slow.
        queue_req(req_mode_e'($urandom_range(1, 3)), $urandom, $urandom, $urandom, $urandom);
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || s_axis_tvalid || predicted_replies.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d draws, %0d reads (%0d with lit pixels) and %0d clears.",
             draws_seen, reads_seen, lit_reads, clears_seen);
    $display("Compared %0d result transactions, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
